// File: rtl/small_graph_reliability_macros.svh
// assertion macros shared by the small graph reliability rtl
// expects clk and rst_n in the scope of the including module
`ifndef SMALL_GRAPH_RELIABILITY_MACROS_SVH
`define SMALL_GRAPH_RELIABILITY_MACROS_SVH

// condition implies consequence in the same cycle
`define SGR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies that $past(sig, n) holds
`define SGR_ASSERT_PAST(lbl, ante, sig, n, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> $past(sig, n)) \
    else $error(msg);

`endif

// File: rtl/sgr_pkg.sv
// shared types, codes and operand tables for the small graph reliability block
// no dependencies
package sgr_pkg;

  localparam int SGR_NUM_EDGES   = 10;
  localparam int SGR_NUM_OPS     = 20;  // ten failure values, then ten working values
  localparam int SGR_GUARD_BITS  = 8;   // integer headroom of the signed datapath
  localparam int SGR_POLY_STAGES = 6;
  localparam int SGR_LATENCY     = SGR_POLY_STAGES + 2;

  typedef logic [3:0] vcount_t;

  localparam vcount_t VC_ONE   = 4'd1;
  localparam vcount_t VC_TWO   = 4'd2;
  localparam vcount_t VC_THREE = 4'd3;
  localparam vcount_t VC_FOUR  = 4'd4;
  localparam vcount_t VC_FIVE  = 4'd5;

  typedef struct packed {
    logic    vld;
    vcount_t vcount;
  } sgr_ctl_t;

  // operand order: a b c d e f q h k l = 0..9, complements = 10..19
  // cut-set groups k6..k15: X Y Z P Q U V U2 V2 x y z
  localparam int KG_N = 10;
  localparam int KG_IDX [KG_N][12] = '{
    '{10, 17, 18, 10, 19, 17,  8,  7, 18,  0,  7,  8},
    '{12, 13, 14, 14, 19, 12,  3,  2, 13,  3,  4,  9},
    '{10, 13, 17, 16, 17, 10,  3,  0, 13,  0,  7,  6},
    '{10, 11, 19, 14, 19, 10,  1,  0, 11,  0,  4,  9},
    '{14, 13, 15, 13, 17, 14,  5,  4, 15,  3,  5,  7},
    '{11, 15, 16, 11, 19, 15,  6,  5, 16,  1,  6,  9},
    '{12, 14, 16, 12, 18, 14,  6,  4, 16,  2,  4,  8},
    '{11, 13, 15, 15, 18, 11,  3,  1, 13,  1,  3,  5},
    '{11, 12, 16, 16, 17, 11,  2,  1, 12,  1,  2,  6},
    '{10, 12, 18, 15, 18, 10,  2,  0, 12,  2,  5,  8}
  };

  // vertex groups k1..k5: M U V U2 V2
  localparam int KH_N = 5;
  localparam int KH_IDX [KH_N][5] = '{
    '{4, 5, 6, 7, 8},
    '{7, 1, 8, 2, 9},
    '{9, 2, 5, 3, 6},
    '{3, 0, 1, 6, 8},
    '{0, 1, 2, 4, 5}
  };

  // outer terms: P1 Q1 xa ya KA P2 Q2 xb yb KB xc yc KC (k index from zero)
  localparam int TM_N = 5;
  localparam int TM_IDX [TM_N][13] = '{
    '{1, 2, 0, 3, 0, 5, 4, 3, 6,  5, 8, 9,  7},
    '{5, 6, 0, 4, 1, 7, 8, 0, 1,  6, 2, 3,  8},
    '{1, 7, 4, 8, 2, 3, 9, 0, 5, 11, 4, 6, 14},
    '{2, 9, 5, 7, 3, 0, 6, 1, 8,  9, 4, 7, 12},
    '{3, 8, 6, 9, 4, 0, 4, 2, 7, 10, 5, 9, 13}
  };

endpackage

// File: rtl/small_graph_reliability.sv
// top level of the small graph reliability block: input stage, polynomial
// pipeline and output select; depends on sgr_pkg, sgr_prep, sgr_poly, macros
//
//  channel  | ports                                      | flow
//  ---------+--------------------------------------------+---------------------------
//  input    | start, busy, in_vertex_count, in_p12..p45  | beat when start && !busy
//  result   | out_valid, out_reliability, out_supported  | one cycle strobe, no hold
//
// one beat per cycle while busy is low; an accepted beat reaches out_valid
// through the input register, the six multiply stages of the five vertex
// polynomial and the output register
// busy is high only while rst_n is low; reset empties the pipeline
// the receiver cannot stall, so the pipeline never holds
`include "small_graph_reliability_macros.svh"
module small_graph_reliability import sgr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_vertex_count,
  input  logic [FRAC_BITS:0] in_p12,
  input  logic [FRAC_BITS:0] in_p13,
  input  logic [FRAC_BITS:0] in_p14,
  input  logic [FRAC_BITS:0] in_p15,
  input  logic [FRAC_BITS:0] in_p23,
  input  logic [FRAC_BITS:0] in_p24,
  input  logic [FRAC_BITS:0] in_p25,
  input  logic [FRAC_BITS:0] in_p34,
  input  logic [FRAC_BITS:0] in_p35,
  input  logic [FRAC_BITS:0] in_p45,
  output logic               out_valid,
  output logic [FRAC_BITS:0] out_reliability,
  output logic               out_supported
);

  localparam int W  = FRAC_BITS + SGR_GUARD_BITS;
  localparam int WS = W + 3;
  localparam logic [FRAC_BITS:0] ONE_OUT = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [WS-1:0] ONE_S = WS'(ONE_OUT);

  logic                                 acc;
  logic [SGR_NUM_EDGES-1:0][FRAC_BITS:0] p_vec;
  logic signed [W-1:0]                  ops [SGR_NUM_OPS];
  sgr_ctl_t                             prep_ctl;
  sgr_ctl_t                             poly_ctl;
  logic signed [W-1:0]                  rel2;
  logic signed [W-1:0]                  rel3;
  logic signed [W-1:0]                  rel4;
  logic signed [W-1:0]                  term [TM_N];
  logic signed [WS-1:0]                 res;
  logic                                 sup;
  logic [FRAC_BITS:0]                   sat_nxt;

  logic               out_valid_r;
  logic [FRAC_BITS:0] out_reliability_r;
  logic               out_supported_r;

  // input beat
  assign busy = ~rst_n;
  assign acc  = start & ~busy;
  assign p_vec = {in_p45, in_p35, in_p34, in_p25, in_p24,
                  in_p23, in_p15, in_p14, in_p13, in_p12};

  sgr_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (acc),
    .vcount_i (in_vertex_count),
    .p_i      (p_vec),
    .ops_o    (ops),
    .ctl_o    (prep_ctl)
  );

  sgr_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .ops_i  (ops),
    .ctl_i  (prep_ctl),
    .rel2_o (rel2),
    .rel3_o (rel3),
    .rel4_o (rel4),
    .term_o (term),
    .ctl_o  (poly_ctl)
  );

  // pick the branch for the vertex count
  always_comb begin
    res = '0;
    sup = 1'b1;
    unique case (poly_ctl.vcount)
      VC_ONE:   res = ONE_S;
      VC_TWO:   res = WS'(rel2);
      VC_THREE: res = WS'(rel3);
      VC_FOUR:  res = WS'(rel4);
      VC_FIVE:  res = ONE_S - (WS'(term[0]) + WS'(term[1]) + WS'(term[2])
                               + WS'(term[3]) + WS'(term[4]));
      default: begin
        res = '0;
        sup = 1'b0;
      end
    endcase
  end

  // saturate to zero..one
  always_comb begin
    if (res < 0) begin
      sat_nxt = '0;
    end else if (res > ONE_S) begin
      sat_nxt = ONE_OUT;
    end else begin
      sat_nxt = res[FRAC_BITS:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= poly_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_reliability_r <= sat_nxt;
    out_supported_r   <= sup;
  end

  assign out_valid       = out_valid_r;
  assign out_reliability = out_reliability_r;
  assign out_supported   = out_supported_r;

  `SGR_ASSERT_PAST(a_out_follows_accept, out_valid, start && !busy, SGR_LATENCY, "result without accepted beat")
  `SGR_ASSERT_PAST(a_supported_count, out_valid && out_supported, in_vertex_count >= VC_ONE && in_vertex_count <= VC_FIVE, SGR_LATENCY, "supported flag for bad count")
  `SGR_ASSERT_IMPL(a_unsupported_zero, out_valid && !out_supported, out_reliability == '0, "unsupported count with nonzero result")
  `SGR_ASSERT_IMPL(a_result_range, out_valid, out_reliability <= ONE_OUT, "result above one")

endmodule

// File: rtl/sgr_prep.sv
// input register stage: clamps edge probabilities and forms failure values
// depends on sgr_pkg
module sgr_prep import sgr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     acc_i,
  input  vcount_t                                  vcount_i,
  input  logic [SGR_NUM_EDGES-1:0][FRAC_BITS:0]    p_i,
  output logic signed [FRAC_BITS+SGR_GUARD_BITS-1:0] ops_o [SGR_NUM_OPS],
  output sgr_ctl_t                                 ctl_o
);

  localparam int W = FRAC_BITS + SGR_GUARD_BITS;
  localparam logic [FRAC_BITS:0] ONE_IN = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] ONE = W'(ONE_IN);

  logic signed [W-1:0] ops_r [SGR_NUM_OPS];
  sgr_ctl_t            ctl_r;

  // control beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.vld    <= acc_i;
      ctl_r.vcount <= vcount_i;
    end
  end

  // clamp to one, keep working and failure values
  always_ff @(posedge clk) begin
    for (int i = 0; i < SGR_NUM_EDGES; i++) begin
      if (p_i[i] > ONE_IN) begin
        ops_r[i]                 <= '0;
        ops_r[i + SGR_NUM_EDGES] <= ONE;
      end else begin
        ops_r[i]                 <= ONE - W'(p_i[i]);
        ops_r[i + SGR_NUM_EDGES] <= W'(p_i[i]);
      end
    end
  end

  assign ops_o = ops_r;
  assign ctl_o = ctl_r;

endmodule

// File: rtl/sgr_poly.sv
// six multiply stages evaluating the 2, 3, 4 and 5 vertex polynomials
// depends on sgr_pkg and the assertion macro header
`include "small_graph_reliability_macros.svh"
module sgr_poly import sgr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic signed [FRAC_BITS+SGR_GUARD_BITS-1:0] ops_i [SGR_NUM_OPS],
  input  sgr_ctl_t                                   ctl_i,
  output logic signed [FRAC_BITS+SGR_GUARD_BITS-1:0] rel2_o,
  output logic signed [FRAC_BITS+SGR_GUARD_BITS-1:0] rel3_o,
  output logic signed [FRAC_BITS+SGR_GUARD_BITS-1:0] rel4_o,
  output logic signed [FRAC_BITS+SGR_GUARD_BITS-1:0] term_o [TM_N],
  output sgr_ctl_t                                   ctl_o
);

  localparam int W = FRAC_BITS + SGR_GUARD_BITS;
  typedef logic signed [W-1:0] fx_t;

  localparam fx_t ONE  = fx_t'({1'b1, {FRAC_BITS{1'b0}}});
  localparam fx_t HALF = fx_t'({1'b1, {(FRAC_BITS-1){1'b0}}});
  localparam logic [2*W-1:0] RND = (2*W)'({1'b1, {(FRAC_BITS-1){1'b0}}});

  // fixed point product, magnitude rounded half away from zero
  function automatic fx_t fm(input fx_t x, input fx_t y);
    logic           neg;
    logic [W-1:0]   mx;
    logic [W-1:0]   my;
    logic [2*W-1:0] pr;
    neg = x[W-1] ^ y[W-1];
    mx  = x[W-1] ? $unsigned(-x) : $unsigned(x);
    my  = y[W-1] ? $unsigned(-y) : $unsigned(y);
    pr  = ((2*W)'(mx) * (2*W)'(my) + RND) >> FRAC_BITS;
    fm  = neg ? -$signed(pr[W-1:0]) : $signed(pr[W-1:0]);
  endfunction

  // operand and control pipeline
  fx_t      ops_r [1:5][SGR_NUM_OPS];
  sgr_ctl_t ctl_r [1:6];

  // three vertex path
  fx_t r3u_r [3];
  fx_t r3p_r [4];
  fx_t rel3_r [3:6];

  // four vertex path
  fx_t t1_r, t2_r, t3_r, t4_r;
  fx_t bd_r, ac_r, ab_r, cd_r, ad_r, bc_r;
  fx_t bde_r, ace_r, abc_r;
  fx_t bdef_r, acef_r, abcd_r;
  fx_t m3s2_r, m3s3_r, m3s4_r;
  fx_t gs_r;
  fx_t rel4_r [5:6];

  // five vertex path
  fx_t kg_xy_r [KG_N];
  fx_t kg_pq_r [KG_N];
  fx_t kg_uv_r [KG_N];
  fx_t kg_uv2_r [KG_N];
  fx_t kg_xy2_r [KG_N];
  fx_t kg_m1_r [KG_N];
  fx_t kg_m2_r [KG_N];
  fx_t kg_m3_r [KG_N];
  fx_t kh_uv_r [KH_N];
  fx_t kh_uv2_r [KH_N];
  fx_t kh_k_r [KH_N];
  fx_t kk_r [KH_N+KG_N];
  fx_t tm_p1_r [1:5][TM_N];
  fx_t tm_p2_r [1:4][TM_N];
  fx_t tm_xa_r [1:3][TM_N];
  fx_t tm_xb_r [1:3][TM_N];
  fx_t tm_xc_r [1:3][TM_N];
  fx_t tm_ma_r [4:5][TM_N];
  fx_t tm_mb_r [TM_N];
  fx_t tm_mc_r [TM_N];
  fx_t tm_in_r [TM_N];
  fx_t term_r [TM_N];
  fx_t rel2_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= SGR_POLY_STAGES; s++) ctl_r[s] <= '0;
    end else begin
      ctl_r[1] <= ctl_i;
      for (int s = 2; s <= SGR_POLY_STAGES; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  // operand delay line
  always_ff @(posedge clk) begin
    ops_r[1] <= ops_i;
    for (int s = 2; s <= 5; s++) ops_r[s] <= ops_r[s-1];
  end

  // stage 1: pairwise products from the operands
  always_ff @(posedge clk) begin
    r3u_r[0] <= fm(ops_i[0], ops_i[1]);
    r3u_r[1] <= fm(ops_i[10], ops_i[1]);
    r3u_r[2] <= fm(ops_i[0], ops_i[11]);
    // four vertex order a b c d e f maps to edges 12 23 34 14 24 13
    t1_r <= fm((ops_i[0] <<< 2) + (ops_i[0] <<< 1), ops_i[4]);
    bd_r <= fm(ops_i[4], ops_i[2]);
    ac_r <= fm(ops_i[0], ops_i[7]);
    ab_r <= fm(ops_i[0], ops_i[4]);
    cd_r <= fm(ops_i[7], ops_i[2]);
    ad_r <= fm(ops_i[0], ops_i[2]);
    bc_r <= fm(ops_i[4], ops_i[7]);
    for (int j = 0; j < KG_N; j++) begin
      kg_xy_r[j]  <= fm(ops_i[KG_IDX[j][0]], ops_i[KG_IDX[j][1]]);
      kg_pq_r[j]  <= fm(ops_i[KG_IDX[j][3]], ops_i[KG_IDX[j][4]]);
      kg_uv_r[j]  <= fm(ops_i[KG_IDX[j][5]], ops_i[KG_IDX[j][6]]);
      kg_uv2_r[j] <= fm(ops_i[KG_IDX[j][7]], ops_i[KG_IDX[j][8]]);
      kg_xy2_r[j] <= fm(ops_i[KG_IDX[j][9]], ops_i[KG_IDX[j][10]]);
    end
    for (int j = 0; j < KH_N; j++) begin
      kh_uv_r[j]  <= fm(ops_i[KH_IDX[j][1]], ops_i[KH_IDX[j][2]]);
      kh_uv2_r[j] <= fm(ops_i[KH_IDX[j][3]], ops_i[KH_IDX[j][4]]);
    end
    for (int j = 0; j < TM_N; j++) begin
      tm_p1_r[1][j] <= fm(ops_i[TM_IDX[j][0]], ops_i[TM_IDX[j][1]]);
      tm_xa_r[1][j] <= fm(ops_i[TM_IDX[j][2]], ops_i[TM_IDX[j][3]]);
      tm_p2_r[1][j] <= fm(ops_i[TM_IDX[j][5]], ops_i[TM_IDX[j][6]]);
      tm_xb_r[1][j] <= fm(ops_i[TM_IDX[j][7]], ops_i[TM_IDX[j][8]]);
      tm_xc_r[1][j] <= fm(ops_i[TM_IDX[j][10]], ops_i[TM_IDX[j][11]]);
    end
  end

  // stage 2: triple products and vertex groups
  always_ff @(posedge clk) begin
    r3p_r[0] <= fm(r3u_r[0], ops_r[1][4]);
    r3p_r[1] <= fm(r3u_r[1], ops_r[1][4]);
    r3p_r[2] <= fm(r3u_r[2], ops_r[1][4]);
    r3p_r[3] <= fm(r3u_r[0], ops_r[1][14]);
    t2_r   <= fm(t1_r, ops_r[1][7]);
    bde_r  <= fm(bd_r, ops_r[1][5]);
    ace_r  <= fm(ac_r, ops_r[1][5]);
    abc_r  <= fm(ab_r, ops_r[1][7]);
    m3s2_r <= fm(ab_r, ops_r[1][5]) + fm(ad_r, ops_r[1][1])
            + fm(bc_r, ops_r[1][1]) + fm(cd_r, ops_r[1][5]);
    for (int j = 0; j < KG_N; j++) begin
      kg_m1_r[j] <= fm(kg_xy_r[j], ops_r[1][KG_IDX[j][2]]);
      kg_m2_r[j] <= fm(kg_pq_r[j], kg_uv_r[j] + kg_uv2_r[j]);
      kg_m3_r[j] <= fm(kg_xy2_r[j], ops_r[1][KG_IDX[j][11]]);
    end
    for (int j = 0; j < KH_N; j++) begin
      kh_k_r[j] <= ONE - fm(ops_r[1][KH_IDX[j][0]], kh_uv_r[j] + kh_uv2_r[j]);
    end
    for (int j = 0; j < TM_N; j++) begin
      tm_p1_r[2][j] <= tm_p1_r[1][j];
      tm_p2_r[2][j] <= tm_p2_r[1][j];
      tm_xa_r[2][j] <= tm_xa_r[1][j];
      tm_xb_r[2][j] <= tm_xb_r[1][j];
      tm_xc_r[2][j] <= tm_xc_r[1][j];
    end
  end

  // stage 3: close the three vertex sum and all k factors
  always_ff @(posedge clk) begin
    rel3_r[3] <= ONE - (r3p_r[0] + r3p_r[1] + r3p_r[2] + r3p_r[3]);
    t3_r   <= fm(t2_r, ops_r[2][2]);
    bdef_r <= fm(bde_r, ops_r[2][1]);
    acef_r <= fm(ace_r, ops_r[2][1]);
    abcd_r <= fm(abc_r, ops_r[2][2]);
    m3s3_r <= m3s2_r;
    for (int j = 0; j < KH_N; j++) kk_r[j] <= kh_k_r[j];
    // k6 scales its last product by one minus four times l
    kk_r[KH_N] <= kg_m1_r[0] + kg_m2_r[0]
                + fm(kg_m3_r[0], ONE - (ops_r[2][9] <<< 2));
    for (int j = 1; j < KG_N; j++) begin
      kk_r[KH_N+j] <= kg_m1_r[j] + kg_m2_r[j] + kg_m3_r[j];
    end
    for (int j = 0; j < TM_N; j++) begin
      tm_p1_r[3][j] <= tm_p1_r[2][j];
      tm_p2_r[3][j] <= tm_p2_r[2][j];
      tm_xa_r[3][j] <= tm_xa_r[2][j];
      tm_xb_r[3][j] <= tm_xb_r[2][j];
      tm_xc_r[3][j] <= tm_xc_r[2][j];
    end
  end

  // stage 4: k weighted products and the four vertex correction terms
  always_ff @(posedge clk) begin
    rel3_r[4] <= rel3_r[3];
    t4_r   <= fm(t3_r, ops_r[3][5]);
    gs_r   <= fm(bdef_r, ops_r[3][0] + ops_r[3][7] - HALF)
            + fm(acef_r, ops_r[3][4] + ops_r[3][2] - HALF)
            + fm(abcd_r, ops_r[3][5] + ops_r[3][1] - HALF);
    m3s4_r <= m3s3_r;
    for (int j = 0; j < TM_N; j++) begin
      tm_p1_r[4][j] <= tm_p1_r[3][j];
      tm_p2_r[4][j] <= tm_p2_r[3][j];
      tm_ma_r[4][j] <= fm(tm_xa_r[3][j], kk_r[TM_IDX[j][4]]);
      tm_mb_r[j]    <= fm(tm_xb_r[3][j], kk_r[TM_IDX[j][9]]);
      tm_mc_r[j]    <= fm(tm_xc_r[3][j], kk_r[TM_IDX[j][12]]);
    end
  end

  // stage 5: inner nesting of the five vertex terms, four vertex result
  always_ff @(posedge clk) begin
    rel3_r[5] <= rel3_r[4];
    rel4_r[5] <= ONE - (fm(t4_r, ops_r[4][1]) - (gs_r <<< 1) + m3s4_r);
    for (int j = 0; j < TM_N; j++) begin
      tm_p1_r[5][j] <= tm_p1_r[4][j];
      tm_ma_r[5][j] <= tm_ma_r[4][j];
      tm_in_r[j]    <= fm(tm_p2_r[4][j], tm_mb_r[j] + tm_mc_r[j]);
    end
  end

  // stage 6: outer products of the five vertex terms
  always_ff @(posedge clk) begin
    rel2_r    <= ops_r[5][SGR_NUM_EDGES];
    rel3_r[6] <= rel3_r[5];
    rel4_r[6] <= rel4_r[5];
    for (int j = 0; j < TM_N; j++) begin
      term_r[j] <= fm(tm_p1_r[5][j], tm_ma_r[5][j] + tm_in_r[j]);
    end
  end

  assign rel2_o = rel2_r;
  assign rel3_o = rel3_r[6];
  assign rel4_o = rel4_r[6];
  assign term_o = term_r;
  assign ctl_o  = ctl_r[SGR_POLY_STAGES];

  `SGR_ASSERT_PAST(a_poly_valid_chain, ctl_o.vld, ctl_i.vld, SGR_POLY_STAGES, "poly beat without entry")

endmodule
